// ===== sv/utf8v_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_pkg
// types and byte constants shared by the utf-8 stream validator
// ----------------------------------------------------------------------------
package utf8v_pkg;

   // allowed range of the first continuation byte after a lead byte
   typedef enum logic [2:0] {
      KIND_FULL = 3'd0,   // 0x80..0xbf
      KIND_E0   = 3'd1,   // 0xa0..0xbf
      KIND_ED   = 3'd2,   // 0x80..0x9f
      KIND_F0   = 3'd3,   // 0x90..0xbf
      KIND_F4   = 3'd4    // 0x80..0x8f
   } range_kind_type;

   typedef struct packed {
      logic [1:0]     pending_count;
      range_kind_type first_range_kind;
      logic           awaiting_first;
      logic           failed;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      pending_count:    2'd0,
      first_range_kind: KIND_FULL,
      awaiting_first:   1'b0,
      failed:           1'b0
   };

   localparam logic [7:0] BYTE_TAB       = 8'h09;
   localparam logic [7:0] BYTE_LF        = 8'h0A;
   localparam logic [7:0] BYTE_CR        = 8'h0D;
   localparam logic [7:0] BYTE_PRINT_LO  = 8'h20;
   localparam logic [7:0] BYTE_PRINT_HI  = 8'h7E;
   localparam logic [7:0] BYTE_LEAD2_LO  = 8'hC2;
   localparam logic [7:0] BYTE_LEAD2_HI  = 8'hDF;
   localparam logic [7:0] BYTE_E0        = 8'hE0;
   localparam logic [7:0] BYTE_ED        = 8'hED;
   localparam logic [7:0] BYTE_LEAD3_HI  = 8'hEF;
   localparam logic [7:0] BYTE_F0        = 8'hF0;
   localparam logic [7:0] BYTE_LEAD4_HI  = 8'hF3;
   localparam logic [7:0] BYTE_F4        = 8'hF4;
   localparam logic [7:0] CONT_LO        = 8'h80;
   localparam logic [7:0] CONT_HI        = 8'hBF;
   localparam logic [7:0] CONT_8F        = 8'h8F;
   localparam logic [7:0] CONT_90        = 8'h90;
   localparam logic [7:0] CONT_9F        = 8'h9F;
   localparam logic [7:0] CONT_A0        = 8'hA0;

endpackage
`default_nettype wire

// ===== sv/utf8v_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8v_check
// next scan state for one byte of the text
// ----------------------------------------------------------------------------
module utf8v_check (
   input  wire  utf8v_pkg::scan_state_type cur_state,
   input  wire  [7:0]                      data_byte,
   output utf8v_pkg::scan_state_type       nxt_state
);
   import utf8v_pkg::*;

   logic cont_ok;
   logic first_ok;

   always_comb begin
      case (cur_state.first_range_kind)
         KIND_E0: first_ok = data_byte inside {[CONT_A0:CONT_HI]};
         KIND_ED: first_ok = data_byte inside {[CONT_LO:CONT_9F]};
         KIND_F0: first_ok = data_byte inside {[CONT_90:CONT_HI]};
         KIND_F4: first_ok = data_byte inside {[CONT_LO:CONT_8F]};
         default: first_ok = data_byte inside {[CONT_LO:CONT_HI]};
      endcase
      cont_ok = cur_state.awaiting_first ? first_ok : (data_byte inside {[CONT_LO:CONT_HI]});
   end

   always_comb begin
      nxt_state = cur_state;
      if (cur_state.failed) begin
         nxt_state = cur_state;
      end else if (cur_state.pending_count != 2'd0) begin
         if (cont_ok) begin
            nxt_state.pending_count    = cur_state.pending_count - 2'd1;
            nxt_state.awaiting_first   = 1'b0;
            nxt_state.first_range_kind = KIND_FULL;
         end else begin
            nxt_state        = SCAN_RESET;
            nxt_state.failed = 1'b1;
         end
      end else begin
         // lead byte position
         if (data_byte inside {BYTE_TAB, BYTE_LF, BYTE_CR, [BYTE_PRINT_LO:BYTE_PRINT_HI]}) begin
            nxt_state = cur_state;
         end else if (data_byte inside {[BYTE_LEAD2_LO:BYTE_LEAD2_HI]}) begin
            nxt_state = '{2'd1, KIND_FULL, 1'b1, 1'b0};
         end else if (data_byte == BYTE_E0) begin
            nxt_state = '{2'd2, KIND_E0, 1'b1, 1'b0};
         end else if (data_byte == BYTE_ED) begin
            nxt_state = '{2'd2, KIND_ED, 1'b1, 1'b0};
         end else if (data_byte inside {[BYTE_E0:BYTE_LEAD3_HI]}) begin
            nxt_state = '{2'd2, KIND_FULL, 1'b1, 1'b0};
         end else if (data_byte == BYTE_F0) begin
            nxt_state = '{2'd3, KIND_F0, 1'b1, 1'b0};
         end else if (data_byte inside {[BYTE_F0:BYTE_LEAD4_HI]}) begin
            nxt_state = '{2'd3, KIND_FULL, 1'b1, 1'b0};
         end else if (data_byte == BYTE_F4) begin
            nxt_state = '{2'd3, KIND_F4, 1'b1, 1'b0};
         end else begin
            nxt_state        = SCAN_RESET;
            nxt_state.failed = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/utf8_stream_validator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_validator
// strict utf-8 checker over a byte stream, one verdict per text
// ----------------------------------------------------------------------------
// Feed the text one byte per beat, with tlast on its final byte. Nothing comes
// out for ordinary bytes; the beat that carries tlast produces exactly one
// result beat whose bit 0 is 1 when the whole text is well-formed utf-8 under
// the strict pattern (ascii limited to tab, lf, cr and 0x20..0x7e, no overlong
// forms, no surrogates, nothing above u+10ffff, no sequence left open) and 0
// otherwise. After the verdict the checker is back in its reset state, ready
// for the next text. One byte is taken every clock cycle unless the input
// stalls as below; the scan state is updated from the input register, and a
// verdict is registered on the result port once its last byte leaves it. A last
// byte waits in the input register only while the previous verdict is still
// held by the receiver, and then the input stalls for as long as that lasts.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [7:0] data_byte
   input  wire        req_tlast,    // last_byte
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata     // [0] text_valid, [7:1] zero
);
   import utf8v_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   scan_state_type state_ff, state_in;
   scan_state_type state_nxt;
   logic           out_valid_ff, out_valid_in;
   logic           out_verdict_ff, out_verdict_in;
   logic           advance;

   utf8v_check u_check (
      .cur_state (state_ff),
      .data_byte (in_byte_ff),
      .nxt_state (state_nxt)
   );

   // a byte without tlast never waits on the result side
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in    = in_valid_ff;
      state_in       = state_ff;
      out_valid_in   = out_valid_ff;
      out_verdict_in = out_verdict_ff;
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            state_in       = SCAN_RESET;
            out_valid_in   = 1'b1;
            out_verdict_in = !state_nxt.failed && (state_nxt.pending_count == 2'd0);
         end else begin
            state_in = state_nxt;
         end
      end
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= SCAN_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      out_verdict_ff <= out_verdict_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_verdict_ff};

   // a failed scan never keeps a sequence open
   assert property (@(posedge clock) disable iff (reset)
      state_ff.failed |-> (state_ff.pending_count == 2'd0 && !state_ff.awaiting_first))
      else $error("failed scan still holds an open sequence");

   // waiting for a first continuation needs an open sequence
   assert property (@(posedge clock) disable iff (reset)
      state_ff.awaiting_first |-> (state_ff.pending_count != 2'd0))
      else $error("first continuation expected with nothing pending");

   // a narrowed range only exists while the first continuation is awaited
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.first_range_kind != KIND_FULL) |-> state_ff.awaiting_first)
      else $error("narrowed range kind outside first continuation");

   // the last beat of a text clears the scan and raises a verdict
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff == SCAN_RESET && rsp_tvalid))
      else $error("last beat did not clear state or give a verdict");

   // a verdict never gets overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !(advance && in_last_ff))
      else $error("verdict overwritten before it was taken");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the strict utf-8 stream validator
// ----------------------------------------------------------------------------
// Texts go in one byte per beat, with tlast on the final byte. A scan model
// follows each accepted byte and queues the verdict of every text. Each
// result beat is checked against the oldest queued verdict. The run starts
// with a short list of hand-picked texts. Random texts follow: mostly
// well-formed characters, mixed with noise, malformed and truncated
// sequences. Sender gaps and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
   import utf8v_pkg::*;

   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned PHASE_BEATS     = 188;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam logic [7:0]  BYTE_MIN        = 8'h00;
   localparam logic [7:0]  BYTE_DEL        = 8'h7F;
   localparam logic [7:0]  LEAD_BAD_LO     = 8'hC0;
   localparam logic [7:0]  LEAD_BAD_HI     = 8'hC1;
   localparam logic [7:0]  LEAD_OUT_LO     = 8'hF5;
   localparam logic [7:0]  BYTE_MAX        = 8'hFF;
   localparam logic [7:0]  BYTE_LETTER_A   = 8'h41;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } text_beat_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] data_byte
   logic       req_tlast  = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [0] text_valid, [7:1] zero

   text_beat_type  beat_q[$];
   logic           verdict_q[$];
   logic [7:0]     text_buf[$];
   scan_state_type scan_st = SCAN_RESET;
   logic           req_fire = 1'b0;
   int unsigned    beats_queued = 0;
   int unsigned    beats_accepted = 0;
   int unsigned    errors = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;

   utf8_stream_validator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
      return (b >= lo) && (b <= hi);
   endfunction

   function automatic logic first_cont_ok(range_kind_type kind, logic [7:0] b);
      case (kind)
         KIND_E0: return in_span(b, CONT_A0, CONT_HI);
         KIND_ED: return in_span(b, CONT_LO, CONT_9F);
         KIND_F0: return in_span(b, CONT_90, CONT_HI);
         KIND_F4: return in_span(b, CONT_LO, CONT_8F);
         default: return in_span(b, CONT_LO, CONT_HI);
      endcase
   endfunction

   function automatic scan_state_type open_seq(logic [1:0] count, range_kind_type kind);
      scan_state_type s;
      s                  = SCAN_RESET;
      s.pending_count    = count;
      s.first_range_kind = kind;
      s.awaiting_first   = 1'b1;
      return s;
   endfunction

   // next scan state after one byte of the text
   function automatic scan_state_type scan_byte(scan_state_type s, logic [7:0] b);
      scan_state_type n;
      logic           ok;
      n = s;
      if (s.failed) begin
         return n;
      end
      if (s.pending_count != 2'd0) begin
         ok = s.awaiting_first ? first_cont_ok(s.first_range_kind, b)
                               : in_span(b, CONT_LO, CONT_HI);
         if (ok) begin
            n.pending_count    = s.pending_count - 2'd1;
            n.awaiting_first   = 1'b0;
            n.first_range_kind = KIND_FULL;
         end else begin
            n        = SCAN_RESET;
            n.failed = 1'b1;
         end
      end else if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR ||
                   in_span(b, BYTE_PRINT_LO, BYTE_PRINT_HI)) begin
         n = s;
      end else if (in_span(b, BYTE_LEAD2_LO, BYTE_LEAD2_HI)) begin
         n = open_seq(2'd1, KIND_FULL);
      end else if (b == BYTE_E0) begin
         n = open_seq(2'd2, KIND_E0);
      end else if (b == BYTE_ED) begin
         n = open_seq(2'd2, KIND_ED);
      end else if (in_span(b, BYTE_E0, BYTE_LEAD3_HI)) begin
         n = open_seq(2'd2, KIND_FULL);
      end else if (b == BYTE_F0) begin
         n = open_seq(2'd3, KIND_F0);
      end else if (in_span(b, BYTE_F0, BYTE_LEAD4_HI)) begin
         n = open_seq(2'd3, KIND_FULL);
      end else if (b == BYTE_F4) begin
         n = open_seq(2'd3, KIND_F4);
      end else begin
         n        = SCAN_RESET;
         n.failed = 1'b1;
      end
      return n;
   endfunction

   // ------------------------------------------------------------- stimulus

   function automatic logic [7:0] pick(logic [7:0] lo, logic [7:0] hi);
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return lo;
      if (r == 1) return hi;
      return 8'($urandom_range(lo, hi));
   endfunction

   task automatic push_beat(logic [7:0] b, logic last);
      text_beat_type t;
      t.data = b;
      t.last = last;
      beat_q.push_back(t);
      beats_queued++;
   endtask

   task automatic push_text(int len, logic [7:0] b0, logic [7:0] b1,
                            logic [7:0] b2, logic [7:0] b3);
      logic [7:0] bs[4];
      bs[0] = b0;
      bs[1] = b1;
      bs[2] = b2;
      bs[3] = b3;
      for (int i = 0; i < len; i++) begin
         push_beat(bs[i], i == len - 1);
      end
   endtask

   task automatic add_good_char();
      logic [7:0] lead;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 3))
               0:       text_buf.push_back(BYTE_TAB);
               1:       text_buf.push_back(BYTE_LF);
               2:       text_buf.push_back(BYTE_CR);
               default: text_buf.push_back(pick(BYTE_PRINT_LO, BYTE_PRINT_HI));
            endcase
         end
         1: begin
            text_buf.push_back(pick(BYTE_LEAD2_LO, BYTE_LEAD2_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         2: begin
            lead = ($urandom_range(0, 3) == 0) ? BYTE_ED : pick(BYTE_E0, BYTE_LEAD3_HI);
            text_buf.push_back(lead);
            if (lead == BYTE_E0) text_buf.push_back(pick(CONT_A0, CONT_HI));
            else if (lead == BYTE_ED) text_buf.push_back(pick(CONT_LO, CONT_9F));
            else text_buf.push_back(pick(CONT_LO, CONT_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         default: begin
            lead = pick(BYTE_F0, BYTE_F4);
            text_buf.push_back(lead);
            if (lead == BYTE_F0) text_buf.push_back(pick(CONT_90, CONT_HI));
            else if (lead == BYTE_F4) text_buf.push_back(pick(CONT_LO, CONT_8F));
            else text_buf.push_back(pick(CONT_LO, CONT_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
      endcase
   endtask

   task automatic add_broken_char();
      case ($urandom_range(0, 6))
         0: begin
            // overlong two-byte lead
            text_buf.push_back(pick(LEAD_BAD_LO, LEAD_BAD_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         1: begin
            // overlong three-byte form
            text_buf.push_back(BYTE_E0);
            text_buf.push_back(pick(CONT_LO, CONT_9F));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         2: begin
            // surrogate
            text_buf.push_back(BYTE_ED);
            text_buf.push_back(pick(CONT_A0, CONT_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         3: begin
            text_buf.push_back(BYTE_F0);
            text_buf.push_back(pick(CONT_LO, CONT_8F));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         4: begin
            // above u+10ffff
            text_buf.push_back(BYTE_F4);
            text_buf.push_back(pick(CONT_90, CONT_HI));
            text_buf.push_back(pick(CONT_LO, CONT_HI));
         end
         5: text_buf.push_back(pick(LEAD_OUT_LO, BYTE_MAX));
         default: text_buf.push_back(pick(CONT_LO, CONT_HI));
      endcase
   endtask

   task automatic add_truncated_char();
      int unsigned start;
      int unsigned n;
      start = text_buf.size();
      add_good_char();
      n = text_buf.size() - start;
      if (n > 1) begin
         repeat ($urandom_range(1, n - 1)) void'(text_buf.pop_back());
      end
   endtask

   task automatic gen_text();
      int unsigned nchars;
      int unsigned r;
      text_buf.delete();
      nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
      for (int i = 0; i < nchars; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80) add_good_char();
         else if (r < 86) text_buf.push_back(8'($urandom_range(0, 255)));
         else if (r < 95) add_broken_char();
         else add_truncated_char();
      end
      for (int i = 0; i < text_buf.size(); i++) begin
         push_beat(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   task automatic note_mismatch(string what, logic [7:0] expd, logic [7:0] actual);
      errors++;
      if (errors <= MAX_REPORTS) begin
         $display("mismatch: %s expected %h actual %h", what, expd, actual);
      end
   endtask

   // --------------------------------------------------------------- driver

   always @(negedge clock) begin
      text_beat_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               t = beat_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= t.data;
               req_tlast  <= t.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // -------------------------------------------------------------- monitor

   always @(posedge clock) begin
      scan_state_type nxt;
      logic           expd;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            beats_accepted++;
            nxt = scan_byte(scan_st, req_tdata);
            if (req_tlast) begin
               verdict_q.push_back(!nxt.failed && nxt.pending_count == 2'd0);
               scan_st = SCAN_RESET;
            end else begin
               scan_st = nxt;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               note_mismatch("unexpected verdict beat", 8'h00, rsp_tdata);
            end else begin
               expd = verdict_q.pop_front();
               if (rsp_tdata !== {7'd0, expd}) begin
                  note_mismatch("text_valid", {7'd0, expd}, rsp_tdata);
               end
            end
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAILURE");
      $finish;
   end

   // ------------------------------------------------------------- sequence

   initial begin
      int unsigned idle_pct[4];
      int unsigned stall_pct[4];
      int unsigned phase_start;
      idle_pct  = '{0, 79, 0, 37};
      stall_pct = '{0, 0, 79, 37};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = idle_pct[p];
         recv_stall_pct = stall_pct[p];
         phase_start    = beats_queued;
         if (p == 0) begin
            // single-byte texts at both ends of the byte range and at 0x7e and 0x7f
            push_text(1, BYTE_MIN, 8'h00, 8'h00, 8'h00);
            push_text(1, BYTE_PRINT_HI, 8'h00, 8'h00, 8'h00);
            push_text(1, BYTE_MAX, 8'h00, 8'h00, 8'h00);
            push_text(1, BYTE_DEL, 8'h00, 8'h00, 8'h00);
            push_text(4, BYTE_TAB, BYTE_LF, BYTE_CR, BYTE_PRINT_LO);
            push_text(3, BYTE_E0, CONT_A0, CONT_HI, 8'h00);
            // surrogate
            push_text(3, BYTE_ED, CONT_A0, CONT_LO, 8'h00);
            push_text(4, BYTE_F4, CONT_8F, CONT_HI, CONT_HI);
            // overlong form, then bytes after the failure
            push_text(3, BYTE_F0, CONT_8F, BYTE_LETTER_A, 8'h00);
            // sequence still open at the last byte
            push_text(1, BYTE_LEAD2_LO, 8'h00, 8'h00, 8'h00);
         end
         while (beats_queued - phase_start < PHASE_BEATS) gen_text();
         while (beats_accepted != beats_queued || verdict_q.size() != 0) begin
            @(negedge clock);
         end
      end

      repeat (8) @(negedge clock);
      if (verdict_q.size() != 0) begin
         errors++;
         $display("%0d verdicts never arrived", verdict_q.size());
      end
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
